// ===== design/lkvc_pkg.sv =====
// Shared types, constants and controller state codes for the LRU key-value cache.
package lkvc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 16;
  localparam int VALUE_W     = 31;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic               op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] data;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic lookup;
    logic update;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_put;
    logic out_free;
  } sts_t;

endpackage

// ===== design/lkvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lkvc_ram #(
  parameter int WIDTH = lkvc_pkg::VALUE_W,
  parameter int DEPTH = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/lkvc_ctrl.sv =====
// Controller state machine: sequences accept, lookup, update and result load.
module lkvc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lkvc_pkg::sts_t sts,
  output lkvc_pkg::cmd_t cmd
);

  lkvc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkvc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      lkvc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = lkvc_pkg::ST_LOOKUP;
        end
      end
      lkvc_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = lkvc_pkg::ST_UPDATE;
      end
      lkvc_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        // a put gives no result
        state_nxt  = sts.is_put ? lkvc_pkg::ST_IDLE : lkvc_pkg::ST_RESP;
      end
      lkvc_pkg::ST_RESP: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/lkvc_dp.sv =====
// Datapath: key CAM, age and valid registers, value RAM and output register.
module lkvc_dp #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wdata,
  input  lkvc_pkg::in_item_t            in_item,
  input  lkvc_pkg::cmd_t                cmd,
  output lkvc_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lkvc_pkg::out_item_t           out_item
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW    = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

  logic [lkvc_pkg::CAP_W-1:0]   cap_r;

  logic                         req_op_r;
  logic [lkvc_pkg::KEY_W-1:0]   req_key_r;
  logic [lkvc_pkg::VALUE_W-1:0] req_value_r;

  logic [ENTRIES-1:0]           valid_r, valid_nxt;
  logic [lkvc_pkg::KEY_W-1:0]   key_r [ENTRIES];
  logic [IDX_W-1:0]             age_r [ENTRIES];
  logic [IDX_W-1:0]             age_nxt [ENTRIES];
  logic [OCC_W-1:0]             occ_r, occ_nxt;

  logic                         hit_r;
  logic [IDX_W-1:0]             hit_idx_r;
  logic [IDX_W-1:0]             hit_age_r;
  logic                         evict_r;
  logic [IDX_W-1:0]             victim_idx_r;
  logic [IDX_W-1:0]             slot_idx_r;

  logic                         out_valid_r;
  lkvc_pkg::out_item_t          out_item_r;

  logic                         match_hit;
  logic [IDX_W-1:0]             match_idx;
  logic [IDX_W-1:0]             match_age;
  logic [ENTRIES-1:0]           victim_vec;
  logic [IDX_W-1:0]             victim_idx;
  logic [IDX_W-1:0]             free_idx;
  logic [OCC_W-1:0]             occ_last;
  logic [CW-1:0]                cap_ext;
  logic [CW-1:0]                eff_cap;
  logic                         evict;

  logic                         put_r;
  logic                         ram_we;
  logic                         ram_re;
  logic [lkvc_pkg::VALUE_W-1:0] ram_rdata;

  assign put_r = (req_op_r == lkvc_pkg::OP_PUT);

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_op_r    <= in_item.op;
      req_key_r   <= in_item.key;
      req_value_r <= in_item.value;
    end
  end

  // Effective capacity: zero counts as one, clamp to the table size
  always_comb begin
    cap_ext = CW'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Parallel compare, oldest-entry and free-slot search
  always_comb begin
    match_hit  = 1'b0;
    match_idx  = '0;
    match_age  = '0;
    victim_idx = '0;
    free_idx   = '0;
    occ_last   = occ_r - 1'b1;
    evict      = (CW'(occ_r) >= eff_cap) && (occ_r != '0);
    for (int i = 0; i < ENTRIES; i++) begin
      victim_vec[i] = valid_r[i] && (OCC_W'(age_r[i]) == occ_last);
      if (valid_r[i] && (key_r[i] == req_key_r)) begin
        match_hit = 1'b1;
        match_idx = IDX_W'(i);
        match_age = match_age | age_r[i];
      end
      if (victim_vec[i]) begin
        victim_idx = IDX_W'(i);
      end
    end
    // lowest free index, counting the entry about to be evicted
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i] || (evict && victim_vec[i])) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r        <= match_hit;
      hit_idx_r    <= match_idx;
      hit_age_r    <= match_age;
      evict_r      <= evict;
      victim_idx_r <= victim_idx;
      slot_idx_r   <= free_idx;
    end
  end

  // Recency, valid and occupancy update
  always_comb begin
    valid_nxt = valid_r;
    age_nxt   = age_r;
    occ_nxt   = occ_r;
    if (cmd.update) begin
      if (hit_r) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (age_r[i] < hit_age_r)) begin
            age_nxt[i] = age_r[i] + 1'b1;
          end
        end
        age_nxt[hit_idx_r] = '0;
      end else if (put_r) begin
        if (evict_r) begin
          valid_nxt[victim_idx_r] = 1'b0;
          age_nxt[victim_idx_r]   = '0;
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_nxt[i]) begin
            age_nxt[i] = age_r[i] + 1'b1;
          end
        end
        valid_nxt[slot_idx_r] = 1'b1;
        age_nxt[slot_idx_r]   = '0;
        occ_nxt = evict_r ? occ_r : occ_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      age_r   <= '{default: '0};
      occ_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && put_r && !hit_r) begin
      key_r[slot_idx_r] <= req_key_r;
    end
  end

  // Values live in RAM; a get reads, a put writes
  assign ram_we = cmd.update && put_r;
  assign ram_re = cmd.update && !put_r && hit_r;

  lkvc_ram #(
    .WIDTH (lkvc_pkg::VALUE_W),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_r ? hit_idx_r : slot_idx_r),
    .wdata (req_value_r),
    .re    (ram_re),
    .raddr (hit_idx_r),
    .rdata (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item_r.found <= hit_r;
      out_item_r.data  <= hit_r ? ram_rdata : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;
  assign sts.is_put   = put_r;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

// ===== design/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
//
// Input channel (in_valid / in_stall / in_item): each transfer is a get or a
// put. A get produces exactly one transfer on the result channel
// (out_valid / out_stall / out_item): found and the stored value on a hit,
// found clear and zero data on a miss. A put produces nothing.
// Configuration: cfg_we with cfg_wdata writes the capacity register; write
// it only while the block is idle.
// Timing: an item is taken in the idle state, looked up in the next cycle
// (parallel key compare over all entries) and applied in the cycle after
// (recency ages and value RAM). A put ends there; a get then goes on to a
// result step that loads the output register from the registered value
// RAM read. The controller handles one item at a time.
// The output register lets a new item enter while a result waits; if the
// receiver holds out_stall, the following get waits in its last step.
// Reset (rst_n low at a clock edge) clears all valid bits, ages and
// occupancy, empties the output register and sets the capacity to 16.
module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lkvc_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lkvc_pkg::out_item_t        out_item
);

  lkvc_pkg::cmd_t cmd;
  lkvc_pkg::sts_t sts;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lkvc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTH
  // At most one step of the sequence is commanded per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.lookup, cmd.update, cmd.load_out}))
    else $error("more than one controller command active");

  // An accepted transfer is looked up in the next cycle, then applied
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (cmd.lookup ##1 cmd.update))
    else $error("accepted item not looked up and applied in order");

  // A loaded result is presented on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  // A put never loads a result
  a_put_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && sts.is_put) |=> !cmd.load_out)
    else $error("put produced a result");
`endif

endmodule

// ===== test/lru_key_value_cache_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the LRU key-value cache, checked against a recency list.
module lru_key_value_cache_tb;

  localparam int CACHE_SLOTS      = lkvc_pkg::ENTRIES_DEF;
  // A put leaves no result behind, so let the block finish one before going on.
  localparam int SETTLE_CYCLES    = 12;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_REPORTS      = 10;
  localparam int PHASE_ITEMS      = 200;

  // One cached line of the predictor; the list below is kept most recent first.
  typedef struct {
    logic [lkvc_pkg::KEY_W-1:0]   key;
    logic [lkvc_pkg::VALUE_W-1:0] value;
  } cache_line_t;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  lkvc_pkg::in_item_t         in_item   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  lkvc_pkg::out_item_t        out_item;

  lru_key_value_cache uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #4 clk = ~clk;

  // Predictor state: recency list, own copy of the capacity register, and the
  // answers still owed by the block for gets already transferred.
  cache_line_t                recency_q[$];
  logic [lkvc_pkg::CAP_W-1:0] capacity_copy = lkvc_pkg::CAP_RESET;
  lkvc_pkg::out_item_t        answer_q[$];

  // Requests waiting for the driver.
  lkvc_pkg::in_item_t request_q[$];

  bit idle_on       = 1'b1;
  int hold_requests = 0;
  int mismatches    = 0;

  // Apply one transferred request to the recency list; a get owes one answer.
  function automatic void apply_request(input lkvc_pkg::in_item_t req);
    int                  hit_idx;
    int                  cap;
    cache_line_t         line;
    lkvc_pkg::out_item_t ans;
    hit_idx = -1;
    for (int i = 0; i < recency_q.size(); i++) begin
      if (recency_q[i].key == req.key) hit_idx = i;
    end
    if (req.op == lkvc_pkg::OP_GET) begin
      if (hit_idx >= 0) begin
        // Hit: answer with the stored value and make the line most recent.
        line = recency_q[hit_idx];
        recency_q.delete(hit_idx);
        recency_q.insert(0, line);
        ans.found = 1'b1;
        ans.data  = line.value;
      end else begin
        ans.found = 1'b0;
        ans.data  = '0;
      end
      answer_q.push_back(ans);
    end else begin
      line.key   = req.key;
      line.value = req.value;
      if (hit_idx >= 0) begin
        recency_q.delete(hit_idx);
      end else begin
        // Capacity zero acts as one, anything above the slot count as the slot count.
        // Only one line goes per insert, even after the capacity has been lowered.
        cap = (capacity_copy == 0) ? 1 :
              (capacity_copy > CACHE_SLOTS) ? CACHE_SLOTS : int'(capacity_copy);
        if (recency_q.size() >= cap) recency_q.delete(recency_q.size() - 1);
      end
      recency_q.insert(0, line);
    end
  endfunction

  function automatic void add_request(input logic op,
                                      input logic [lkvc_pkg::KEY_W-1:0] key,
                                      input logic [lkvc_pkg::VALUE_W-1:0] value);
    lkvc_pkg::in_item_t req;
    req.op    = op;
    req.key   = key;
    req.value = value;
    request_q.push_back(req);
  endfunction

  // Driver: advance to the next request once the current one has transferred.
  // A gap is armed with an item and opens only after that item has gone.
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) apply_request(in_item);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (request_q.size() > 0) begin
          in_item  <= request_q.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every result transfer against the oldest answer owed, and
  // drive out_stall. A long hold is counted here, so the sender keeps
  // offering requests until the block fills up and stalls its input.
  int                  stall_left   = 0;
  int                  long_left    = 0;
  int                  holds_served = 0;
  lkvc_pkg::out_item_t wanted;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("result with no answer owed: found=%0b data=%h",
                     out_item.found, out_item.data);
          mismatches++;
        end else begin
          wanted = answer_q.pop_front();
          if (out_item.found !== wanted.found || out_item.data !== wanted.data) begin
            if (mismatches < MAX_REPORTS)
              $display("mismatch: expected found=%0b data=%h, got found=%0b data=%h",
                       wanted.found, wanted.data, out_item.found, out_item.data);
            mismatches++;
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served <= hold_requests;
        long_left    <= LONG_HOLD_CYCLES;
        out_stall    <= 1'b1;
      end else if (long_left > 0) begin
        long_left <= long_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        // Start a stall burst, this cycle included; stall_left holds the rest of it.
        stall_left <= $urandom_range(0, 3);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Hold the sender until every request has transferred and every answer has
  // come, then let a trailing put settle. Sample between edges so that the
  // driver's updates at the edge are already visible.
  task automatic wait_idle();
    @(negedge clk);
    while (request_q.size() > 0 || in_valid || answer_q.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
    @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_wdata     <= cap;
    capacity_copy  = cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic over a small key pool so that hits, updates and evictions
  // are common; a few keys come from the whole range and mostly miss.
  task automatic run_phase(input int count, input int pool_size);
    logic [lkvc_pkg::KEY_W-1:0] pool[$];
    logic [lkvc_pkg::KEY_W-1:0] k;
    repeat (pool_size) pool.push_back(lkvc_pkg::KEY_W'($urandom));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 6) == 0) k = lkvc_pkg::KEY_W'($urandom);
      else k = pool[$urandom_range(0, pool_size - 1)];
      add_request(($urandom_range(0, 1) == 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET, k,
                  lkvc_pkg::VALUE_W'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty cache, extreme keys and values, update of a present key.
    add_request(lkvc_pkg::OP_GET, 16'h0000, 31'h7FFFFFFF);
    add_request(lkvc_pkg::OP_PUT, 16'h0000, 31'h00000000);
    add_request(lkvc_pkg::OP_PUT, 16'hFFFF, 31'h7FFFFFFF);
    add_request(lkvc_pkg::OP_GET, 16'h0000, 31'h7FFFFFFF);
    add_request(lkvc_pkg::OP_GET, 16'hFFFF, 31'h00000000);
    add_request(lkvc_pkg::OP_PUT, 16'h0000, 31'h2AAAAAAA);
    add_request(lkvc_pkg::OP_GET, 16'h0000, 31'h00000000);
    add_request(lkvc_pkg::OP_PUT, 16'h5555, 31'h55555555);
    add_request(lkvc_pkg::OP_GET, 16'h1234, 31'h00000000);
    wait_idle();

    // Shrink the capacity below the occupancy: the next new key evicts one line.
    set_capacity(5'd1);
    add_request(lkvc_pkg::OP_PUT, 16'hAAAA, 31'h00000001);
    add_request(lkvc_pkg::OP_GET, 16'hFFFF, 31'h00000000);
    add_request(lkvc_pkg::OP_GET, 16'h0000, 31'h00000000);
    add_request(lkvc_pkg::OP_GET, 16'h5555, 31'h00000000);
    add_request(lkvc_pkg::OP_GET, 16'hAAAA, 31'h00000000);
    wait_idle();

    // Capacity zero acts as one.
    set_capacity(5'd0);
    add_request(lkvc_pkg::OP_PUT, 16'h0F0F, 31'h0F0F0F0F);
    add_request(lkvc_pkg::OP_PUT, 16'hF0F0, 31'h70F0F0F0);
    add_request(lkvc_pkg::OP_GET, 16'h0F0F, 31'h00000000);
    add_request(lkvc_pkg::OP_GET, 16'hF0F0, 31'h00000000);
    add_request(lkvc_pkg::OP_PUT, 16'hF0F0, 31'h00000003);
    add_request(lkvc_pkg::OP_GET, 16'hF0F0, 31'h00000000);
    wait_idle();

    // Capacity above the slot count acts as the slot count; hold the receiver
    // off for a long stretch while requests keep coming.
    set_capacity(5'd31);
    run_phase(PHASE_ITEMS, 24);
    hold_requests++;
    wait_idle();

    set_capacity(5'd2);
    run_phase(PHASE_ITEMS, 5);
    wait_idle();

    set_capacity(5'd17);
    run_phase(PHASE_ITEMS, 40);
    wait_idle();

    set_capacity(5'd1);
    run_phase(PHASE_ITEMS, 3);
    wait_idle();

    set_capacity(5'd7);
    run_phase(PHASE_ITEMS, 12);
    wait_idle();

    set_capacity(lkvc_pkg::CAP_W'($urandom_range(0, 31)));
    run_phase(PHASE_ITEMS, 20);
    wait_idle();

    set_capacity(5'd16);
    run_phase(PHASE_ITEMS, 20);
    wait_idle();

    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    set_capacity(5'd4);
    run_phase(PHASE_ITEMS, 8);
    wait_idle();

    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("lru_key_value_cache_tb OK");
    end else begin
      $display("lru_key_value_cache_tb NOT OK");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("lru_key_value_cache_tb NOT OK");
    $finish;
  end

endmodule
